// ===== rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared constants, the opcode type and the control word that travels with
// each item down the pipeline.
// ----------------------------------------------------------------------------
package cau_pkg;

  // Default word format: signed Q8.24.
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 24;

  // Operation codes as carried on req_type.
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MAG = 3'd4,
    OP_CMP = 3'd5
  } op_e;

  // Per-item control and flags passed between the pipeline sections.
  typedef struct packed {
    op_e  op;
    logic equal;
    logic greater;
    logic less;
    logic div_zero;
    logic ovf;
    logic neg_re;
    logic neg_im;
    logic big_re;
    logic big_im;
  } ctl_t;

endpackage

// ===== rtl/cau_front.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit front end
// Four register stages: operand capture, products, sums of products, and
// magnitude/saturation preparation for the iterative section.
// ----------------------------------------------------------------------------
module cau_front #(
  parameter int W = cau_pkg::WORD_BITS,
  parameter int F = cau_pkg::FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           req_type_i,
  input  logic signed [W-1:0]  a_re_i,
  input  logic signed [W-1:0]  a_im_i,
  input  logic signed [W-1:0]  b_re_i,
  input  logic signed [W-1:0]  b_im_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cau_pkg::ctl_t        ctl_o,
  output logic [W-1:0]         res_re_o,
  output logic [W-1:0]         res_im_o,
  output logic [3*W+F:0]       rem_re_o,
  output logic [3*W+F:0]       rem_im_o,
  output logic [3*W+F:0]       den_o,
  output logic [2*W-1:0]       x_o
);
  import cau_pkg::*;

  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int DW = 3 * W + F + 1;
  localparam logic [SW-1:0] LIM_NEG = SW'(1) << (W - 1);
  localparam logic [SW-1:0] LIM_POS = LIM_NEG - SW'(1);

  // Magnitude of a signed sum.
  function automatic logic [SW-1:0] mag_of(input logic signed [SW-1:0] v);
    return v[SW-1] ? SW'(-v) : SW'(v);
  endfunction

  // Saturate a magnitude with sign into a word; the top bit is the overflow.
  function automatic logic [W:0] sat_word(input logic [SW-1:0] mag, input logic neg);
    logic [SW-1:0] lim;
    logic [SW-1:0] m;
    logic          o;
    logic [W-1:0]  val;
    lim = neg ? LIM_NEG : LIM_POS;
    o   = (mag > lim);
    m   = o ? lim : mag;
    val = m[W-1:0];
    if (neg) begin
      val = -val;
    end
    return {o, val};
  endfunction

  // Stage valid bits and the advance chain.
  logic [3:0] v_q;
  logic [3:0] adv;

  assign adv[3] = !v_q[3] || out_ready_i;
  assign adv[2] = !v_q[2] || adv[3];
  assign adv[1] = !v_q[1] || adv[2];
  assign adv[0] = !v_q[0] || adv[1];
  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      if (adv[1]) v_q[1] <= v_q[0];
      if (adv[2]) v_q[2] <= v_q[1];
      if (adv[3]) v_q[3] <= v_q[2];
    end
  end

  // Stage 1: operand capture.
  op_e                op1_q;
  logic signed [W-1:0] ar1_q, ai1_q, br1_q, bi1_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      op1_q <= op_e'(req_type_i);
      ar1_q <= a_re_i;
      ai1_q <= a_im_i;
      br1_q <= b_re_i;
      bi1_q <= b_im_i;
    end
  end

  // Stage 2: all partial products, part sums and the equality test.
  op_e                  op2_q;
  logic                 eq2_q, sar2_q, sai2_q;
  logic signed [W:0]    sum_re2_d, sum_im2_d, sum_re2_q, sum_im2_q;
  logic signed [PW-1:0] p_arbr2_q, p_aibi2_q, p_arbi2_q, p_aibr2_q;
  logic signed [PW-1:0] p_arar2_q, p_aiai2_q, p_brbr2_q, p_bibi2_q;

  always_comb begin
    if (op1_q == OP_SUB) begin
      sum_re2_d = (W+1)'(ar1_q) - (W+1)'(br1_q);
      sum_im2_d = (W+1)'(ai1_q) - (W+1)'(bi1_q);
    end else begin
      sum_re2_d = (W+1)'(ar1_q) + (W+1)'(br1_q);
      sum_im2_d = (W+1)'(ai1_q) + (W+1)'(bi1_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      op2_q     <= op1_q;
      eq2_q     <= (ar1_q == br1_q) && (ai1_q == bi1_q);
      sar2_q    <= ar1_q[W-1];
      sai2_q    <= ai1_q[W-1];
      sum_re2_q <= sum_re2_d;
      sum_im2_q <= sum_im2_d;
      p_arbr2_q <= PW'(ar1_q) * PW'(br1_q);
      p_aibi2_q <= PW'(ai1_q) * PW'(bi1_q);
      p_arbi2_q <= PW'(ar1_q) * PW'(bi1_q);
      p_aibr2_q <= PW'(ai1_q) * PW'(br1_q);
      p_arar2_q <= PW'(ar1_q) * PW'(ar1_q);
      p_aiai2_q <= PW'(ai1_q) * PW'(ai1_q);
      p_brbr2_q <= PW'(br1_q) * PW'(br1_q);
      p_bibi2_q <= PW'(bi1_q) * PW'(bi1_q);
    end
  end

  // Stage 3: sums of products and squared magnitudes.
  op_e                  op3_q;
  logic                 eq3_q, sar3_q, sai3_q;
  logic signed [W:0]    sum_re3_q, sum_im3_q;
  logic signed [SW-1:0] prm3_q, pim3_q, prd3_q, pid3_q;
  logic [PW-1:0]        den3_q, x3_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      op3_q     <= op2_q;
      eq3_q     <= eq2_q;
      sar3_q    <= sar2_q;
      sai3_q    <= sai2_q;
      sum_re3_q <= sum_re2_q;
      sum_im3_q <= sum_im2_q;
      prm3_q    <= SW'(p_arbr2_q) - SW'(p_aibi2_q);
      pim3_q    <= SW'(p_arbi2_q) + SW'(p_aibr2_q);
      prd3_q    <= SW'(p_arbr2_q) + SW'(p_aibi2_q);
      pid3_q    <= SW'(p_aibr2_q) - SW'(p_arbi2_q);
      den3_q    <= $unsigned(p_brbr2_q) + $unsigned(p_bibi2_q);
      x3_q      <= $unsigned(p_arar2_q) + $unsigned(p_aiai2_q);
    end
  end

  // Stage 4: saturation of direct results, compare flags and setup of the divider.
  ctl_t          ctl_d;
  logic [W-1:0]  res_re_d, res_im_d;
  logic [W:0]    sat_re, sat_im;
  logic [DW-1:0] rem_re_d, rem_im_d, den_sh;

  assign rem_re_d = DW'(mag_of(prd3_q)) << F;
  assign rem_im_d = DW'(mag_of(pid3_q)) << F;
  assign den_sh   = DW'(den3_q) << W;

  always_comb begin
    ctl_d    = '0;
    ctl_d.op = op3_q;
    res_re_d = '0;
    res_im_d = '0;
    sat_re   = '0;
    sat_im   = '0;
    case (op3_q)
      OP_ADD, OP_SUB: begin
        sat_re   = sat_word(mag_of(SW'(sum_re3_q)), sum_re3_q[W]);
        sat_im   = sat_word(mag_of(SW'(sum_im3_q)), sum_im3_q[W]);
        res_re_d = sat_re[W-1:0];
        res_im_d = sat_im[W-1:0];
        ctl_d.ovf = sat_re[W] || sat_im[W];
      end
      OP_MUL: begin
        sat_re   = sat_word(mag_of(prm3_q) >> F, prm3_q[SW-1]);
        sat_im   = sat_word(mag_of(pim3_q) >> F, pim3_q[SW-1]);
        res_re_d = sat_re[W-1:0];
        res_im_d = sat_im[W-1:0];
        ctl_d.ovf = sat_re[W] || sat_im[W];
      end
      OP_DIV: begin
        ctl_d.div_zero = (den3_q == '0);
        ctl_d.neg_re   = ctl_d.div_zero ? sar3_q : prd3_q[SW-1];
        ctl_d.neg_im   = ctl_d.div_zero ? sai3_q : pid3_q[SW-1];
        ctl_d.big_re   = (rem_re_d >= den_sh);
        ctl_d.big_im   = (rem_im_d >= den_sh);
      end
      OP_CMP: begin
        ctl_d.equal   = eq3_q;
        ctl_d.greater = (x3_q > den3_q);
        ctl_d.less    = (x3_q < den3_q);
      end
      default: begin
        ctl_d.op = op3_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      ctl_o    <= ctl_d;
      res_re_o <= res_re_d;
      res_im_o <= res_im_d;
      rem_re_o <= rem_re_d;
      rem_im_o <= rem_im_d;
      den_o    <= DW'(den3_q);
      x_o      <= x3_q;
    end
  end

endmodule

// ===== rtl/cau_iter.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit iterative section
// One register stage per quotient and root bit: two restoring divider lanes
// share the denominator, and a digit-by-digit square root runs alongside.
// ----------------------------------------------------------------------------
module cau_iter #(
  parameter int W = cau_pkg::WORD_BITS,
  parameter int F = cau_pkg::FRAC_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  cau_pkg::ctl_t   ctl_i,
  input  logic [W-1:0]    res_re_i,
  input  logic [W-1:0]    res_im_i,
  input  logic [3*W+F:0]  rem_re_i,
  input  logic [3*W+F:0]  rem_im_i,
  input  logic [3*W+F:0]  den_i,
  input  logic [2*W-1:0]  x_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output cau_pkg::ctl_t   ctl_o,
  output logic [W-1:0]    res_re_o,
  output logic [W-1:0]    res_im_o,
  output logic [W-1:0]    q_re_o,
  output logic [W-1:0]    q_im_o,
  output logic [W-1:0]    root_o
);
  import cau_pkg::*;

  localparam int DW = 3 * W + F + 1;
  localparam int XW = 2 * W + 1;

  // Stage registers, one entry per stage.
  logic [W-1:0]  v_q;
  logic [W-1:0]  adv;
  ctl_t          ctl_q    [W];
  logic [W-1:0]  res_re_q [W];
  logic [W-1:0]  res_im_q [W];
  logic [DW-1:0] rr_q     [W];
  logic [DW-1:0] ri_q     [W];
  logic [DW-1:0] dn_q     [W];
  logic [XW-1:0] xr_q     [W];
  logic [W-1:0]  qr_q     [W];
  logic [W-1:0]  qi_q     [W];
  logic [W-1:0]  rt_q     [W];

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[W-1];
  assign ctl_o       = ctl_q[W-1];
  assign res_re_o    = res_re_q[W-1];
  assign res_im_o    = res_im_q[W-1];
  assign q_re_o      = qr_q[W-1];
  assign q_im_o      = qi_q[W-1];
  assign root_o      = rt_q[W-1];

  for (genvar k = 0; k < W; k++) begin : g_stage
    localparam int J = W - 1 - k;

    logic          v_in;
    ctl_t          ctl_in;
    logic [W-1:0]  re_in, im_in, qr_in, qi_in, rt_in;
    logic [DW-1:0] rr_in, ri_in, dn_in, dsh;
    logic [XW-1:0] xr_in, cand;
    logic [DW-1:0] rr_d, ri_d;
    logic [XW-1:0] xr_d;
    logic [W-1:0]  qr_d, qi_d, rt_d;

    // Stage input comes from the front end or from the stage before.
    if (k == 0) begin : g_first
      assign v_in   = in_valid_i;
      assign ctl_in = ctl_i;
      assign re_in  = res_re_i;
      assign im_in  = res_im_i;
      assign rr_in  = rem_re_i;
      assign ri_in  = rem_im_i;
      assign dn_in  = den_i;
      assign xr_in  = XW'(x_i);
      assign qr_in  = '0;
      assign qi_in  = '0;
      assign rt_in  = '0;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign ctl_in = ctl_q[k-1];
      assign re_in  = res_re_q[k-1];
      assign im_in  = res_im_q[k-1];
      assign rr_in  = rr_q[k-1];
      assign ri_in  = ri_q[k-1];
      assign dn_in  = dn_q[k-1];
      assign xr_in  = xr_q[k-1];
      assign qr_in  = qr_q[k-1];
      assign qi_in  = qi_q[k-1];
      assign rt_in  = rt_q[k-1];
    end

    // Advance when empty or when the next stage moves.
    if (k == W - 1) begin : g_last
      assign adv[k] = !v_q[k] || out_ready_i;
    end else begin : g_mid
      assign adv[k] = !v_q[k] || adv[k+1];
    end

    assign dsh  = dn_in << J;
    assign cand = (XW'(rt_in) << (J + 1)) + (XW'(1) << (2 * J));

    // One quotient bit per lane and one root bit.
    always_comb begin
      rr_d = rr_in;
      ri_d = ri_in;
      xr_d = xr_in;
      qr_d = qr_in;
      qi_d = qi_in;
      rt_d = rt_in;
      if (rr_in >= dsh) begin
        rr_d    = rr_in - dsh;
        qr_d[J] = 1'b1;
      end
      if (ri_in >= dsh) begin
        ri_d    = ri_in - dsh;
        qi_d[J] = 1'b1;
      end
      if (xr_in >= cand) begin
        xr_d    = xr_in - cand;
        rt_d[J] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        ctl_q[k]    <= ctl_in;
        res_re_q[k] <= re_in;
        res_im_q[k] <= im_in;
        rr_q[k]     <= rr_d;
        ri_q[k]     <= ri_d;
        dn_q[k]     <= dn_in;
        xr_q[k]     <= xr_d;
        qr_q[k]     <= qr_d;
        qi_q[k]     <= qi_d;
        rt_q[k]     <= rt_d;
      end
    end
  end

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Add, subtract, multiply, divide, magnitude and compare on complex operands
// in signed fixed point, with saturation and overflow/divide-by-zero flags.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one opcode and two
//   complex operands per transfer; the output channel (out_valid_o /
//   out_stall_i) returns exactly one result per input, in order.
//   A transfer takes place on a rising edge with valid high and stall low.
//   Throughput is one item per cycle while the output is not stalled. Each
//   item passes through four front-end stages (capture, products, sums,
//   saturation setup), one stage per quotient/root bit in the shared
//   divider and square-root pipeline, and the output register.
//   When the receiver stalls, results hold in the output register and the
//   stages behind it keep filling bubbles; input stall rises only once every
//   stage holds an item. Nothing is dropped or repeated.
//   Reset (rst_ni low, asynchronous) empties the pipeline; no items are in
//   flight and out_valid_o is low afterwards.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS,
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  req_type_i,
  input  logic signed [WORD_BITS-1:0] a_re_i,
  input  logic signed [WORD_BITS-1:0] a_im_i,
  input  logic signed [WORD_BITS-1:0] b_re_i,
  input  logic signed [WORD_BITS-1:0] b_im_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [WORD_BITS-1:0] res_re_o,
  output logic signed [WORD_BITS-1:0] res_im_o,
  output logic                        equal_o,
  output logic                        greater_o,
  output logic                        less_o,
  output logic                        div_zero_o,
  output logic                        overflow_o
);
  import cau_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int DW = 3 * W + F + 1;
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  // Saturate a quotient magnitude; the top bit of the result is overflow.
  function automatic logic [W:0] sat_q(input logic [W-1:0] q, input logic neg,
                                       input logic big);
    logic [W:0]   lim;
    logic         o;
    logic [W-1:0] val;
    lim = neg ? (W+1)'(WMIN) : (W+1)'(WMAX);
    o   = big || ({1'b0, q} > lim);
    val = o ? lim[W-1:0] : q;
    if (neg) begin
      val = -val;
    end
    return {o, val};
  endfunction

  // Front end to iterative section.
  logic          f_valid, f_ready, in_ready;
  ctl_t          f_ctl;
  logic [W-1:0]  f_res_re, f_res_im;
  logic [DW-1:0] f_rem_re, f_rem_im, f_den;
  logic [2*W-1:0] f_x;

  cau_front #(.W(W), .F(F)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .req_type_i  (req_type_i),
    .a_re_i      (a_re_i),
    .a_im_i      (a_im_i),
    .b_re_i      (b_re_i),
    .b_im_i      (b_im_i),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .ctl_o       (f_ctl),
    .res_re_o    (f_res_re),
    .res_im_o    (f_res_im),
    .rem_re_o    (f_rem_re),
    .rem_im_o    (f_rem_im),
    .den_o       (f_den),
    .x_o         (f_x)
  );

  assign in_stall_o = !in_ready;

  // Iterative section to output stage.
  logic         i_valid, out_adv;
  ctl_t         i_ctl;
  logic [W-1:0] i_res_re, i_res_im, i_q_re, i_q_im, i_root;

  cau_iter #(.W(W), .F(F)) u_iter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .ctl_i       (f_ctl),
    .res_re_i    (f_res_re),
    .res_im_i    (f_res_im),
    .rem_re_i    (f_rem_re),
    .rem_im_i    (f_rem_im),
    .den_i       (f_den),
    .x_i         (f_x),
    .out_valid_o (i_valid),
    .out_ready_i (out_adv),
    .ctl_o       (i_ctl),
    .res_re_o    (i_res_re),
    .res_im_o    (i_res_im),
    .q_re_o      (i_q_re),
    .q_im_o      (i_q_im),
    .root_o      (i_root)
  );

  // Final result selection.
  logic [W-1:0] re_d, im_d;
  logic         ovf_d;
  logic [W:0]   qs_re, qs_im;

  assign qs_re = sat_q(i_q_re, i_ctl.neg_re, i_ctl.big_re);
  assign qs_im = sat_q(i_q_im, i_ctl.neg_im, i_ctl.big_im);

  always_comb begin
    re_d  = i_res_re;
    im_d  = i_res_im;
    ovf_d = i_ctl.ovf;
    case (i_ctl.op)
      OP_DIV: begin
        if (i_ctl.div_zero) begin
          re_d  = i_ctl.neg_re ? WMIN : WMAX;
          im_d  = i_ctl.neg_im ? WMIN : WMAX;
          ovf_d = 1'b1;
        end else begin
          re_d  = qs_re[W-1:0];
          im_d  = qs_im[W-1:0];
          ovf_d = qs_re[W] || qs_im[W];
        end
      end
      OP_MAG: begin
        re_d  = i_root[W-1] ? WMAX : i_root;
        im_d  = '0;
        ovf_d = i_root[W-1];
      end
      default: begin
        re_d = i_res_re;
      end
    endcase
  end

  // Output register.
  logic out_v_q;

  assign out_adv     = !out_v_q || !out_stall_i;
  assign out_valid_o = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= i_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      res_re_o   <= re_d;
      res_im_o   <= im_d;
      equal_o    <= i_ctl.equal;
      greater_o  <= i_ctl.greater;
      less_o     <= i_ctl.less;
      div_zero_o <= i_ctl.div_zero;
      overflow_o <= ovf_d;
    end
  end

endmodule
